// File: rtl/core/sar_pixel_sample_converter_assert.svh
// assertion macros for the pixel sample converter
// expects clk and rst_n in the including module's scope
`ifndef SAR_PIXEL_SAMPLE_CONVERTER_ASSERT_SVH
`define SAR_PIXEL_SAMPLE_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SPSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPSC_ASSERT_NOW(lbl, ante, cons, msg)
`define SPSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/spsc_pkg.sv
// shared types, constants and float helpers of the pixel sample converter
// no dependencies
package spsc_pkg;

  typedef enum logic [2:0] {
    FMT_U8      = 3'd0,
    FMT_U16     = 3'd1,
    FMT_U32     = 3'd2,
    FMT_F32     = 3'd3,
    FMT_HALF    = 3'd4,
    FMT_CF32    = 3'd5,
    FMT_CHALF   = 3'd6,
    FMT_F32_ALT = 3'd7
  } fmt_t;

  localparam logic [31:0] F32_INF   = 32'h7F800000;
  localparam logic [31:0] F32_QUIET = 32'h00400000;
  localparam int SQRT_STAGES = 5;
  localparam int SQRT_STEPS  = 5;
  localparam logic [50:0] SQ_TOP_BIT = 51'(1) << 48;

  typedef struct packed {
    logic [6:0] sh;
    logic [8:0] ebase;
  } rnd_t;

  typedef struct packed {
    logic        eol;
    logic        is_int;
    logic        is_cplx;
    logic [31:0] a;
    logic [31:0] b;
  } s1_t;

  typedef struct packed {
    logic        eol;
    logic        byp;
    logic [31:0] byp_val;
    logic        is_int;
    logic [31:0] u;
    logic [5:0]  upos;
    logic [47:0] pr;
    logic [47:0] pi;
    logic [7:0]  er;
    logic [7:0]  ei;
    logic        infr;
    logic        infi;
  } s2_t;

  typedef struct packed {
    logic        eol;
    logic        byp;
    logic [31:0] byp_val;
    logic        is_int;
    logic [31:0] u;
    rnd_t        ru;
    logic [47:0] pr;
    logic [47:0] pi;
    rnd_t        rr;
    rnd_t        ri;
    logic        infr;
    logic        infi;
  } s3_t;

  typedef struct packed {
    logic        eol;
    logic        byp;
    logic [31:0] byp_val;
    logic [31:0] p1;
    logic [31:0] p2;
  } s4_t;

  typedef struct packed {
    logic        eol;
    logic        byp;
    logic [31:0] byp_val;
    logic [27:0] s;
    logic [7:0]  eb;
    logic        inf;
  } s5_t;

  typedef struct packed {
    logic        eol;
    logic        byp;
    logic [31:0] byp_val;
    logic [31:0] sum;
  } s6_t;

  typedef struct packed {
    logic [50:0] num;
    logic [50:0] r;
  } sq_t;

  typedef struct packed {
    logic        eol;
    logic        byp;
    logic [31:0] byp_val;
    logic [8:0]  bexp;
    sq_t         sq;
  } sqs_t;

  function automatic logic [5:0] msb_pos(logic [63:0] x);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [9:0]  man;
    logic [3:0]  n;
    logic [10:0] mn;
    logic [7:0]  be;
    sgn = {h[15], 31'b0};
    e   = h[14:10];
    man = h[9:0];
    n   = 4'(6'd10 - msb_pos({54'b0, man}));
    mn  = {1'b0, man} << n;
    be  = 8'd113 - {4'b0, n};
    if (e == 5'd0) begin
      if (man == 10'd0) begin
        return sgn;
      end
      return sgn | {1'b0, be, mn[9:0], 13'b0};
    end
    if (e == 5'd31) begin
      return sgn | F32_INF;
    end
    return sgn | {1'b0, 3'b0, e, 23'b0} + {1'b0, 8'd112, 23'b0} | {19'b0, man, 3'b0} << 10;
  endfunction

  function automatic logic is_nan(logic [31:0] b);
    return b[30:0] > F32_INF[30:0];
  endfunction

  // round x >> sh to nearest even and pack on top of the exponent base
  function automatic logic [31:0] round_pack(logic [79:0] x, logic [6:0] sh,
                                             logic [8:0] ebase);
    logic [79:0] t;
    logic [79:0] mask;
    logic        g;
    logic        st;
    logic [33:0] sum;
    t    = x >> (sh - 7'd1);
    mask = ~({80{1'b1}} << (sh - 7'd1));
    st   = |(x & mask);
    g    = t[0];
    sum  = {2'b0, ebase, 23'b0} + {9'b0, t[25:1]} + {33'b0, g & (st | t[1])};
    if (sum >= {2'b0, F32_INF}) begin
      return F32_INF;
    end
    return sum[31:0];
  endfunction

  // shift and exponent base for the square of a float with exponent e
  function automatic rnd_t sq_prep(logic [47:0] p, logic [7:0] e);
    rnd_t               rv;
    logic [5:0]         l;
    logic signed [10:0] sh_s;
    logic signed [10:0] sh_n;
    logic signed [10:0] sh_m;
    logic signed [10:0] biased;
    l      = msb_pos({16'b0, p});
    sh_s   = 11'sd175 - $signed({2'b0, e, 1'b0});
    sh_n   = $signed({5'b0, l}) + 11'sd1;
    sh_m   = (sh_s > sh_n) ? sh_s : sh_n;
    biased = $signed({5'b0, l}) + $signed({2'b0, e, 1'b0}) - 11'sd173;
    rv.sh  = (sh_m > 11'sd79) ? 7'd79 : sh_m[6:0];
    rv.ebase = (biased > 11'sd0) ? 9'(biased - 11'sd1) : 9'd0;
    if (p == 48'd0) begin
      rv.sh    = 7'd1;
      rv.ebase = 9'd0;
    end
    return rv;
  endfunction

  function automatic sq_t sqrt_step(sq_t s, logic [50:0] bit_v);
    sq_t         o;
    logic [50:0] t;
    t = s.r + bit_v;
    if (s.num >= t) begin
      o.num = s.num - t;
      o.r   = (s.r >> 1) + bit_v;
    end else begin
      o.num = s.num;
      o.r   = s.r >> 1;
    end
    return o;
  endfunction

endpackage

// File: rtl/core/spsc_pixel_if.sv
// input word channel: raw pixel and end of line flag
// no dependencies
interface spsc_pixel_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_pixel;
  logic        end_of_line;
  modport source (output valid, raw_pixel, end_of_line, input ready);
  modport sink (input valid, raw_pixel, end_of_line, output ready);
endinterface

// File: rtl/core/spsc_sample_if.sv
// output word channel: float32 sample and line flag
// no dependencies
interface spsc_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_value;
  logic        last_of_line;
  modport source (output valid, sample_value, last_of_line, input ready);
  modport sink (input valid, sample_value, last_of_line, output ready);
endinterface

// File: rtl/core/spsc_cfg_if.sv
// configuration write channel for the pixel format register
// no dependencies
interface spsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] pixel_format;
  modport source (output valid, pixel_format, input ready);
  modport sink (input valid, pixel_format, output ready);
endinterface

// File: rtl/core/spsc_unpack.sv
// format decode and mantissa squaring, two pipeline stages
// depends on spsc_pkg
module spsc_unpack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [63:0]        raw,
  input  logic               eol,
  input  spsc_pkg::fmt_t     fmt,
  output logic               s2_vld,
  output spsc_pkg::s2_t      s2
);

  logic          s1_vld_r;
  spsc_pkg::s1_t s1_r, s1_nxt;
  spsc_pkg::s2_t s2_r, s2_nxt;
  logic          s2_vld_r;
  logic [7:0]    fr, fi;
  logic [23:0]   mr, mi;

  always_comb begin
    s1_nxt         = '0;
    s1_nxt.eol     = eol;
    s1_nxt.a       = raw[31:0];
    case (fmt)
      spsc_pkg::FMT_U8: begin
        s1_nxt.is_int = 1'b1;
        s1_nxt.a      = {24'b0, raw[7:0]};
      end
      spsc_pkg::FMT_U16: begin
        s1_nxt.is_int = 1'b1;
        s1_nxt.a      = {16'b0, raw[15:0]};
      end
      spsc_pkg::FMT_U32: begin
        s1_nxt.is_int = 1'b1;
      end
      spsc_pkg::FMT_HALF: begin
        s1_nxt.a = spsc_pkg::half_to_single(raw[15:0]);
      end
      spsc_pkg::FMT_CF32: begin
        s1_nxt.is_cplx = 1'b1;
        s1_nxt.a       = raw[63:32];
        s1_nxt.b       = raw[31:0];
      end
      spsc_pkg::FMT_CHALF: begin
        s1_nxt.is_cplx = 1'b1;
        s1_nxt.a       = spsc_pkg::half_to_single(raw[31:16]);
        s1_nxt.b       = spsc_pkg::half_to_single(raw[15:0]);
      end
      default: begin
        s1_nxt.a = raw[31:0];
      end
    endcase
  end

  always_comb begin
    fr = s1_r.a[30:23];
    fi = s1_r.b[30:23];
    mr = {fr != 8'd0, s1_r.a[22:0]};
    mi = {fi != 8'd0, s1_r.b[22:0]};
    s2_nxt         = '0;
    s2_nxt.eol     = s1_r.eol;
    s2_nxt.is_int  = s1_r.is_int;
    s2_nxt.u       = s1_r.a;
    s2_nxt.upos    = spsc_pkg::msb_pos({32'b0, s1_r.a});
    s2_nxt.pr      = 48'(mr) * 48'(mr);
    s2_nxt.pi      = 48'(mi) * 48'(mi);
    s2_nxt.er      = (fr == 8'd0) ? 8'd1 : fr;
    s2_nxt.ei      = (fi == 8'd0) ? 8'd1 : fi;
    s2_nxt.infr    = fr == 8'hFF;
    s2_nxt.infi    = fi == 8'hFF;
    s2_nxt.byp_val = s1_r.a;
    if (!s1_r.is_int && !s1_r.is_cplx) begin
      s2_nxt.byp = 1'b1;
    end else if (s1_r.is_cplx && spsc_pkg::is_nan(s1_r.a)) begin
      s2_nxt.byp     = 1'b1;
      s2_nxt.byp_val = s1_r.a | spsc_pkg::F32_QUIET;
    end else if (s1_r.is_cplx && spsc_pkg::is_nan(s1_r.b)) begin
      s2_nxt.byp     = 1'b1;
      s2_nxt.byp_val = s1_r.b | spsc_pkg::F32_QUIET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign s2_vld = s2_vld_r;
  assign s2     = s2_r;

endmodule

// File: rtl/core/spsc_square.sv
// normalize and round the squares and the integer word, two stages
// depends on spsc_pkg
module spsc_square (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           s2_vld,
  input  spsc_pkg::s2_t  s2,
  output logic           s4_vld,
  output spsc_pkg::s4_t  s4
);

  spsc_pkg::s3_t s3_r, s3_nxt;
  spsc_pkg::s4_t s4_r, s4_nxt;
  logic          s3_vld_r;
  logic          s4_vld_r;

  always_comb begin
    s3_nxt          = '0;
    s3_nxt.eol      = s2.eol;
    s3_nxt.byp      = s2.byp;
    s3_nxt.byp_val  = s2.byp_val;
    s3_nxt.is_int   = s2.is_int;
    s3_nxt.u        = s2.u;
    s3_nxt.ru.sh    = {1'b0, s2.upos} + 7'd9;
    s3_nxt.ru.ebase = (s2.u == 32'd0) ? 9'd0 : {3'b0, s2.upos} + 9'd126;
    s3_nxt.pr       = s2.pr;
    s3_nxt.pi       = s2.pi;
    s3_nxt.rr       = spsc_pkg::sq_prep(s2.pr, s2.er);
    s3_nxt.ri       = spsc_pkg::sq_prep(s2.pi, s2.ei);
    s3_nxt.infr     = s2.infr;
    s3_nxt.infi     = s2.infi;
  end

  always_comb begin
    s4_nxt         = '0;
    s4_nxt.eol     = s3_r.eol;
    s4_nxt.byp     = s3_r.byp;
    s4_nxt.byp_val = s3_r.byp_val;
    if (s3_r.is_int) begin
      s4_nxt.byp     = 1'b1;
      s4_nxt.byp_val = spsc_pkg::round_pack({16'b0, s3_r.u, 32'b0}, s3_r.ru.sh,
                                            s3_r.ru.ebase);
    end
    s4_nxt.p1 = s3_r.infr ? spsc_pkg::F32_INF :
                spsc_pkg::round_pack({8'b0, s3_r.pr, 24'b0}, s3_r.rr.sh, s3_r.rr.ebase);
    s4_nxt.p2 = s3_r.infi ? spsc_pkg::F32_INF :
                spsc_pkg::round_pack({8'b0, s3_r.pi, 24'b0}, s3_r.ri.sh, s3_r.ri.ebase);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign s4_vld = s4_vld_r;
  assign s4     = s4_r;

endmodule

// File: rtl/core/spsc_add.sv
// float32 sum of the squares and radicand setup, three stages
// depends on spsc_pkg
module spsc_add (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            s4_vld,
  input  spsc_pkg::s4_t   s4,
  output logic            s7_vld,
  output spsc_pkg::sqs_t  s7
);

  spsc_pkg::s5_t  s5_r, s5_nxt;
  spsc_pkg::s6_t  s6_r, s6_nxt;
  spsc_pkg::sqs_t s7_r, s7_nxt;
  logic           s5_vld_r, s6_vld_r, s7_vld_r;

  logic [31:0] big, sml;
  logic [7:0]  eb, es, d;
  logic [23:0] mb, ms;
  logic [26:0] ext_s, al;
  logic        st;

  always_comb begin
    if (s4.p1[30:0] >= s4.p2[30:0]) begin
      big = s4.p1;
      sml = s4.p2;
    end else begin
      big = s4.p2;
      sml = s4.p1;
    end
    eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb    = {big[30:23] != 8'd0, big[22:0]};
    ms    = {sml[30:23] != 8'd0, sml[22:0]};
    d     = eb - es;
    ext_s = {ms, 3'b0};
    if (d >= 8'd27) begin
      al = 27'd0;
      st = |ms;
    end else begin
      al = ext_s >> d;
      st = |(ext_s & ~({27{1'b1}} << d));
    end
    s5_nxt         = '0;
    s5_nxt.eol     = s4.eol;
    s5_nxt.byp     = s4.byp;
    s5_nxt.byp_val = s4.byp_val;
    s5_nxt.s       = ({1'b0, mb, 3'b0} + {1'b0, al}) | {27'b0, st};
    s5_nxt.eb      = eb;
    s5_nxt.inf     = (s4.p1 >= spsc_pkg::F32_INF) || (s4.p2 >= spsc_pkg::F32_INF);
  end

  always_comb begin
    s6_nxt         = '0;
    s6_nxt.eol     = s5_r.eol;
    s6_nxt.byp     = s5_r.byp;
    s6_nxt.byp_val = s5_r.byp_val;
    if (s5_r.inf) begin
      s6_nxt.sum = spsc_pkg::F32_INF;
    end else if (s5_r.s[27]) begin
      s6_nxt.sum = spsc_pkg::round_pack({52'b0, s5_r.s}, 7'd4, {1'b0, s5_r.eb});
    end else begin
      s6_nxt.sum = spsc_pkg::round_pack({52'b0, s5_r.s}, 7'd3, {1'b0, s5_r.eb} - 9'd1);
    end
  end

  logic [7:0]         f;
  logic [5:0]         n;
  logic [23:0]        m0;
  logic [25:0]        m;
  logic signed [9:0]  e, e2;

  always_comb begin
    f  = s6_r.sum[30:23];
    n  = 6'd23 - spsc_pkg::msb_pos({41'b0, s6_r.sum[22:0]});
    if (f == 8'd0) begin
      m0 = {1'b0, s6_r.sum[22:0]} << n;
      e  = -10'sd149 - $signed({4'b0, n});
    end else begin
      m0 = {1'b1, s6_r.sum[22:0]};
      e  = $signed({2'b0, f}) - 10'sd150;
    end
    if (e[0]) begin
      m  = {1'b0, m0, 1'b0};
      e2 = e - 10'sd1;
    end else begin
      m  = {m0, 2'b0};
      e2 = e - 10'sd2;
    end
    s7_nxt         = '0;
    s7_nxt.eol     = s6_r.eol;
    s7_nxt.byp     = s6_r.byp;
    s7_nxt.byp_val = s6_r.byp_val;
    s7_nxt.bexp    = 9'((e2 >>> 1) + 10'sd139);
    s7_nxt.sq.num  = {1'b0, m, 24'b0};
    s7_nxt.sq.r    = 51'd0;
    if (!s6_r.byp && ((s6_r.sum == 32'd0) || (s6_r.sum >= spsc_pkg::F32_INF))) begin
      s7_nxt.byp     = 1'b1;
      s7_nxt.byp_val = s6_r.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
    end
  end

  assign s7_vld = s7_vld_r;
  assign s7     = s7_r;

endmodule

// File: rtl/core/spsc_sqrt.sv
// pipelined digit-by-digit square root and final rounding stage
// depends on spsc_pkg
module spsc_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            s7_vld,
  input  spsc_pkg::sqs_t  s7,
  output logic            out_vld,
  output logic [31:0]     out_val,
  output logic            out_eol
);

  spsc_pkg::sqs_t st_r   [spsc_pkg::SQRT_STAGES];
  spsc_pkg::sqs_t st_nxt [spsc_pkg::SQRT_STAGES];
  logic [spsc_pkg::SQRT_STAGES-1:0] vld_r;
  logic        out_vld_r;
  logic [31:0] out_val_r, out_val_nxt;
  logic        out_eol_r;

  always_comb begin
    spsc_pkg::sqs_t cur;
    for (int k = 0; k < spsc_pkg::SQRT_STAGES; k++) begin
      cur = (k == 0) ? s7 : st_r[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < spsc_pkg::SQRT_STEPS; j++) begin
        cur.sq = spsc_pkg::sqrt_step(cur.sq,
                   spsc_pkg::SQ_TOP_BIT >> (2 * (k * spsc_pkg::SQRT_STEPS + j)));
      end
      st_nxt[k] = cur;
    end
  end

  spsc_pkg::sqs_t lst;
  logic [23:0]    q;
  logic [24:0]    q1;
  logic           rnd;

  always_comb begin
    lst = st_r[spsc_pkg::SQRT_STAGES-1];
    q   = lst.sq.r[24:1];
    rnd = lst.sq.r[0] & ((lst.sq.num != 51'd0) | q[0]);
    q1  = {1'b0, q} + {24'b0, rnd};
    if (lst.byp) begin
      out_val_nxt = lst.byp_val;
    end else if (q1[24]) begin
      out_val_nxt = {1'b0, lst.bexp[7:0] + 8'd1, 23'b0};
    end else begin
      out_val_nxt = {1'b0, lst.bexp[7:0], q1[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[spsc_pkg::SQRT_STAGES-2:0], s7_vld};
      out_vld_r <= vld_r[spsc_pkg::SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < spsc_pkg::SQRT_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
      out_val_r <= out_val_nxt;
      out_eol_r <= lst.eol;
    end
  end

  assign out_vld = out_vld_r;
  assign out_val = out_val_r;
  assign out_eol = out_eol_r;

endmodule

// File: rtl/core/sar_pixel_sample_converter.sv
// 13 register stages lie between an accepted input word and its output word
// throughput: one word per cycle; the whole pipeline holds while the output word waits
// decode and multiply two stages, rounding of the squares two, the sum three, sqrt five, output one
// reset clears the pipeline valid bits and sets pixel_format to u8
// depends on spsc_pkg, the channel interfaces and spsc_unpack/square/add/sqrt
`include "sar_pixel_sample_converter_assert.svh"
module sar_pixel_sample_converter (
  input  logic          clk,
  input  logic          rst_n,
  spsc_pixel_if.sink    in_ch,
  spsc_sample_if.source out_ch,
  spsc_cfg_if.sink      cfg_ch
);

  spsc_pkg::fmt_t fmt_r;
  logic           en;
  logic           s2_vld, s4_vld, s7_vld, out_vld;
  spsc_pkg::s2_t  s2;
  spsc_pkg::s4_t  s4;
  spsc_pkg::sqs_t s7;
  logic [3:0]     vld_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= spsc_pkg::FMT_U8;
    end else if (cfg_ch.valid) begin
      fmt_r <= spsc_pkg::fmt_t'(cfg_ch.pixel_format);
    end
  end

  // stall everything while the output word is not taken
  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  spsc_unpack u_unpack (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_ch.valid),
    .raw    (in_ch.raw_pixel),
    .eol    (in_ch.end_of_line),
    .fmt    (fmt_r),
    .s2_vld (s2_vld),
    .s2     (s2)
  );

  spsc_square u_square (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .s2_vld (s2_vld),
    .s2     (s2),
    .s4_vld (s4_vld),
    .s4     (s4)
  );

  spsc_add u_add (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .s4_vld (s4_vld),
    .s4     (s4),
    .s7_vld (s7_vld),
    .s7     (s7)
  );

  spsc_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .s7_vld  (s7_vld),
    .s7      (s7),
    .out_vld (out_vld),
    .out_val (out_ch.sample_value),
    .out_eol (out_ch.last_of_line)
  );

  assign out_ch.valid = out_vld;
  assign vld_q        = {s2_vld, s4_vld, s7_vld, out_vld};

  `SPSC_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_q), "pipeline moved during a stall")
  `SPSC_ASSERT_NEXT(a_word_enters, in_ch.valid && en ##1 en, s2_vld, "accepted word lost")
  `SPSC_ASSERT_NEXT(a_bubble, !in_ch.valid && en ##1 en, !s2_vld, "word invented")
  `SPSC_ASSERT_NOW(a_stall_cause, s2_vld && !en, out_ch.valid, "stall without output word")

endmodule
